// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl top file base64_stream_decoder.sv
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define B64D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup of the Base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    // result queue depth, a power of two of at least MAX_ITEMS
    localparam int unsigned QUEUE_DEPTH = 8;
    // most result items one character can cause
    localparam int unsigned MAX_ITEMS = 4;
    localparam int unsigned ITEM_CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [15:0] MAX_BYTES_RESET = 16'd300;

    // alphabet codes beyond the 64 sextet values
    localparam logic [6:0] CODE_SKIP = 7'd64;
    localparam logic [6:0] CODE_PAD  = 7'd65;
    localparam logic [6:0] CODE_BAD  = 7'd66;

    // final item status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        MODE_DECODE,
        MODE_PADDED,
        MODE_DROP
    } text_mode_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_data;
        logic [1:0]  decode_status;
        logic [15:0] byte_count;
        logic        last_of_run;
    } result_t;

    // items produced by one accepted character, lowest index first
    typedef struct packed {
        logic [ITEM_CNT_W-1:0]      count;
        result_t [MAX_ITEMS-1:0]    items;
    } result_batch_t;

    // standard alphabet to sextet, or one of the special codes
    function automatic logic [6:0] classify(input logic [7:0] ch);
        logic [7:0] diff;
        logic [6:0] code;
        diff = 8'd0;
        code = CODE_BAD;
        if (ch >= "A" && ch <= "Z")
        begin
            diff = ch - 8'h41;
            code = diff[6:0];
        end
        else if (ch >= "a" && ch <= "z")
        begin
            diff = ch - 8'h61 + 8'd26;
            code = diff[6:0];
        end
        else if (ch >= "0" && ch <= "9")
        begin
            diff = ch - 8'h30 + 8'd52;
            code = diff[6:0];
        end
        else if (ch == "+")
        begin
            code = 7'd62;
        end
        else if (ch == "/")
        begin
            code = 7'd63;
        end
        else if (ch == 8'h0A)
        begin
            code = CODE_SKIP;
        end
        else if (ch == "=")
        begin
            code = CODE_PAD;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_decode.sv =====
// ----------------------------------------------------------------------------
// b64d_decode
// Per-text decode state and the single-pass logic that turns one accepted
// character into up to four result items.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_decode
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   fire,
    input  wire logic [7:0]             text_char,
    input  wire logic                   end_of_text,
    output b64d_pkg::result_batch_t     batch
);

    logic [15:0]            max_reg;
    logic [17:0]            buf_reg, buf_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [15:0]            dc_reg, dc_next;
    b64d_pkg::text_mode_t   mode_reg, mode_next;
    logic [1:0]             err_reg, err_next;

    // state after the character itself
    logic [6:0]             code;
    logic [17:0]            mid_buf;
    logic [1:0]             mid_cnt;
    logic [15:0]            mid_dc;
    b64d_pkg::text_mode_t   mid_mode;
    logic [1:0]             mid_err;
    logic                   grp_emit;
    logic [23:0]            group;
    logic [16:0]            grp_sum;

    // end of text handling
    logic                   tail2, tail1;
    logic [16:0]            tail_sum;
    logic [15:0]            end_dc;
    logic [1:0]             end_err;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= b64d_pkg::MAX_BYTES_RESET;
        else if (cfg_we)
            max_reg <= cfg_data;
    end

    // character step: classify and gather sextets
    always_comb
    begin
        code     = b64d_pkg::classify(text_char);
        mid_buf  = buf_reg;
        mid_cnt  = cnt_reg;
        mid_dc   = dc_reg;
        mid_mode = mode_reg;
        mid_err  = err_reg;
        grp_emit = 1'b0;
        group    = {buf_reg, code[5:0]};
        grp_sum  = {1'b0, dc_reg} + 17'd3;
        if (mode_reg == b64d_pkg::MODE_DECODE)
        begin
            priority if (code == b64d_pkg::CODE_BAD)
            begin
                mid_err  = b64d_pkg::STATUS_INVALID;
                mid_mode = b64d_pkg::MODE_DROP;
            end
            else if (code == b64d_pkg::CODE_PAD)
            begin
                mid_mode = b64d_pkg::MODE_PADDED;
            end
            else if (code != b64d_pkg::CODE_SKIP)
            begin
                if (cnt_reg == 2'd3)
                begin
                    if (grp_sum > {1'b0, max_reg})
                    begin
                        mid_err  = b64d_pkg::STATUS_OVERFLOW;
                        mid_mode = b64d_pkg::MODE_DROP;
                    end
                    else
                    begin
                        grp_emit = 1'b1;
                        mid_dc   = grp_sum[15:0];
                    end
                    mid_buf = 18'd0;
                    mid_cnt = 2'd0;
                end
                else
                begin
                    mid_buf = {buf_reg[11:0], code[5:0]};
                    mid_cnt = cnt_reg + 2'd1;
                end
            end
        end
    end

    // end step: flush the partial group and close the text
    always_comb
    begin
        tail2    = 1'b0;
        tail1    = 1'b0;
        end_dc   = mid_dc;
        end_err  = mid_err;
        tail_sum = {1'b0, mid_dc} + ((mid_cnt == 2'd3) ? 17'd2 : 17'd1);
        if (end_of_text && mid_mode != b64d_pkg::MODE_DROP
            && (mid_cnt == 2'd3 || mid_cnt == 2'd2))
        begin
            if (tail_sum > {1'b0, max_reg})
            begin
                end_err = b64d_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                tail2  = (mid_cnt == 2'd3);
                tail1  = (mid_cnt == 2'd2);
                end_dc = tail_sum[15:0];
            end
        end
    end

    // next state
    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        dc_next   = dc_reg;
        mode_next = mode_reg;
        err_next  = err_reg;
        if (fire)
        begin
            if (end_of_text)
            begin
                buf_next  = 18'd0;
                cnt_next  = 2'd0;
                dc_next   = 16'd0;
                mode_next = b64d_pkg::MODE_DECODE;
                err_next  = b64d_pkg::STATUS_OK;
            end
            else
            begin
                buf_next  = mid_buf;
                cnt_next  = mid_cnt;
                dc_next   = mid_dc;
                mode_next = mid_mode;
                err_next  = mid_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= 18'd0;
            cnt_reg  <= 2'd0;
            dc_reg   <= 16'd0;
            mode_reg <= b64d_pkg::MODE_DECODE;
            err_reg  <= b64d_pkg::STATUS_OK;
        end
        else
        begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            dc_reg   <= dc_next;
            mode_reg <= mode_next;
            err_reg  <= err_next;
        end
    end

    // result items: data bytes first, then the final status item
    always_comb
    begin
        batch = '0;
        for (int i = 0; i < b64d_pkg::MAX_ITEMS; i++)
            batch.items[i].is_data = 1'b1;
        if (grp_emit)
        begin
            batch.items[0].data_byte = group[23:16];
            batch.items[1].data_byte = group[15:8];
            batch.items[2].data_byte = group[7:0];
            batch.count = b64d_pkg::ITEM_CNT_W'(3);
        end
        else if (tail2)
        begin
            batch.items[0].data_byte = mid_buf[17:10];
            batch.items[1].data_byte = mid_buf[9:2];
            batch.count = b64d_pkg::ITEM_CNT_W'(2);
        end
        else if (tail1)
        begin
            batch.items[0].data_byte = mid_buf[11:4];
            batch.count = b64d_pkg::ITEM_CNT_W'(1);
        end
        if (end_of_text)
        begin
            batch.items[batch.count[1:0]].data_byte     = 8'd0;
            batch.items[batch.count[1:0]].is_data       = 1'b0;
            batch.items[batch.count[1:0]].decode_status = end_err;
            batch.items[batch.count[1:0]].byte_count    = end_dc;
            batch.items[batch.count[1:0]].last_of_run   = 1'b1;
            batch.count = batch.count + b64d_pkg::ITEM_CNT_W'(1);
        end
        if (!fire)
            batch.count = '0;
    end

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Result queue: takes up to four items in one cycle, hands out one item per
// cycle while out_ready is high on the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue
#(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH,
    localparam int unsigned PTR_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire b64d_pkg::result_batch_t batch,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output b64d_pkg::result_t           out_item,
    output logic [CNT_W-1:0]            level
);

    localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(DEPTH - b64d_pkg::MAX_ITEMS);

    b64d_pkg::result_t      mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       level_reg, level_next;
    logic                   pop;

    // room for a full batch of items
    assign in_ready  = (level_reg <= READY_LIMIT);
    assign out_valid = (level_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid & out_ready;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(batch.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + CNT_W'(batch.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // item storage, written at consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < b64d_pkg::MAX_ITEMS; i++)
        begin
            if (b64d_pkg::ITEM_CNT_W'(i) < batch.count)
                mem[wr_ptr_reg + PTR_W'(i)] <= batch.items[i];
        end
    end

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text decoder, one character per input item, decoded bytes and one
// closing status item per text on the output stream.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one character per item in tdata, tlast marks the text's last one
//   m_axis: tuser high for a data byte item, low for the final status item;
//           tlast is high on the status item, which carries status and count
//   cfg_we/cfg_data: writes max_output_bytes, only while the block is idle
// order: results of a character enter the result queue at its accept and reach m_axis behind older items
// throughput: one character per cycle while the result queue has room for
//   four items; the output side drains one item per cycle while m_axis_tready is high,
//   so the queue depth (QUEUE_DEPTH) sets how long a three-byte group burst can be absorbed
// reset: decode state clears, the queue empties, max_output_bytes goes to 300
// stall: a stalled receiver holds the head item; s_axis_tready drops once
//   fewer than four free queue slots remain, so no item is ever lost
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module base64_stream_decoder
#(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // configuration
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data,
    // character input
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // text_char[7:0]
    input  wire logic           s_axis_tlast,
    // result output
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // data_byte[7:0], decode_status[9:8],
                                                // byte_count[25:10], zero[31:26]
    output logic                m_axis_tuser,   // is_data
    output logic                m_axis_tlast
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LEVEL_MAX = CNT_W'(QUEUE_DEPTH);

    logic                       fire;
    b64d_pkg::result_batch_t    batch;
    b64d_pkg::result_t          head;
    logic [CNT_W-1:0]           level;

    assign fire = s_axis_tvalid & s_axis_tready;

    // per-character decode
    b64d_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fire        (fire),
        .text_char   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .batch       (batch)
    );

    // result queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .batch     (batch),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (head),
        .level     (level)
    );

    // output packing
    assign m_axis_tdata = {6'd0, head.byte_count, head.decode_status, head.data_byte};
    assign m_axis_tuser = head.is_data;
    assign m_axis_tlast = head.last_of_run;

    // checks
    `B64D_ASSERT(a_level_bound, level <= LEVEL_MAX, "result queue overfilled")
    `B64D_ASSERT_NEXT(a_end_gives_item, fire && s_axis_tlast, m_axis_tvalid,
        "no result after end of text")
    `B64D_ASSERT(a_data_not_last, !(m_axis_tvalid && m_axis_tuser && m_axis_tlast),
        "data item marked as last")

endmodule

`default_nettype wire

// ===== sim/base64_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the Base64 stream decoder. Texts go in one character
// per item on s_axis; a scoreboard decodes each accepted character on its own
// and checks every data byte and closing status item from m_axis, field by
// field and in order. Directed texts cover the alphabet ends, line feed, pad,
// invalid characters, short tails and errors; random texts, mostly well formed,
// run under several max_output_bytes limits, from zero to the full range.
// ----------------------------------------------------------------------------

module base64_stream_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no item moving on either side before the run is given up
    localparam int unsigned STALL_LIMIT = 2000;
    // receiver hold-off that fills the result queue
    localparam int unsigned LONG_HOLD_CYCLES = 120;

    // ------------------------------------------------------------------------
    // scoreboard: own decoder state and the queue of expected result items
    // ------------------------------------------------------------------------
    class decoder_scoreboard;
        int unsigned          byte_limit;
        logic [17:0]          held_sextets;
        int unsigned          held_count;
        int unsigned          bytes_out;
        b64d_pkg::text_mode_t mode;
        logic [1:0]           status;
        b64d_pkg::result_t    expected_q[$];
        int unsigned          errors;

        function new();
            byte_limit = b64d_pkg::MAX_BYTES_RESET;
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            held_sextets = '0;
            held_count = 0;
            bytes_out = 0;
            mode = b64d_pkg::MODE_DECODE;
            status = b64d_pkg::STATUS_OK;
        endfunction

        function void set_limit(logic [15:0] value);
            byte_limit = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // alphabet lookup, line feed and pad get their own codes
        function logic [6:0] sextet_of(logic [7:0] ch);
            if (ch >= "A" && ch <= "Z")
            begin
                return 7'(ch - "A");
            end
            if (ch >= "a" && ch <= "z")
            begin
                return 7'(ch - "a" + 8'd26);
            end
            if (ch >= "0" && ch <= "9")
            begin
                return 7'(ch - "0" + 8'd52);
            end
            if (ch == "+")
            begin
                return 7'd62;
            end
            if (ch == "/")
            begin
                return 7'd63;
            end
            if (ch == 8'h0A)
            begin
                return b64d_pkg::CODE_SKIP;
            end
            if (ch == "=")
            begin
                return b64d_pkg::CODE_PAD;
            end
            return b64d_pkg::CODE_BAD;
        endfunction

        function void add_item(logic [7:0] data, logic is_data, logic [1:0] st,
                               logic [15:0] count, logic closing);
            b64d_pkg::result_t r;
            r.data_byte = data;
            r.is_data = is_data;
            r.decode_status = st;
            r.byte_count = count;
            r.last_of_run = closing;
            expected_q.push_back(r);
        endfunction

        function void latch_error(logic [1:0] st);
            status = st;
            mode = b64d_pkg::MODE_DROP;
        endfunction

        // decode one accepted character
        function void note_char(logic [7:0] ch, logic end_of_text);
            logic [6:0]  code;
            logic [23:0] group;
            if (mode == b64d_pkg::MODE_DECODE)
            begin
                code = sextet_of(ch);
                if (code == b64d_pkg::CODE_BAD)
                begin
                    latch_error(b64d_pkg::STATUS_INVALID);
                end
                else if (code == b64d_pkg::CODE_PAD)
                begin
                    mode = b64d_pkg::MODE_PADDED;
                end
                else if (code != b64d_pkg::CODE_SKIP)
                begin
                    if (held_count == 3)
                    begin
                        group = {held_sextets, code[5:0]};
                        if (bytes_out + 3 > byte_limit)
                        begin
                            latch_error(b64d_pkg::STATUS_OVERFLOW);
                        end
                        else
                        begin
                            add_item(group[23:16], 1'b1, b64d_pkg::STATUS_OK, 16'd0, 1'b0);
                            add_item(group[15:8], 1'b1, b64d_pkg::STATUS_OK, 16'd0, 1'b0);
                            add_item(group[7:0], 1'b1, b64d_pkg::STATUS_OK, 16'd0, 1'b0);
                            bytes_out += 3;
                        end
                        held_sextets = '0;
                        held_count = 0;
                    end
                    else
                    begin
                        held_sextets = {held_sextets[11:0], code[5:0]};
                        held_count++;
                    end
                end
            end
            // tail bytes and the closing status item
            if (end_of_text)
            begin
                if (mode != b64d_pkg::MODE_DROP)
                begin
                    if (held_count == 3)
                    begin
                        if (bytes_out + 2 > byte_limit)
                        begin
                            latch_error(b64d_pkg::STATUS_OVERFLOW);
                        end
                        else
                        begin
                            add_item(held_sextets[17:10], 1'b1, b64d_pkg::STATUS_OK,
                                     16'd0, 1'b0);
                            add_item(held_sextets[9:2], 1'b1, b64d_pkg::STATUS_OK,
                                     16'd0, 1'b0);
                            bytes_out += 2;
                        end
                    end
                    else if (held_count == 2)
                    begin
                        if (bytes_out + 1 > byte_limit)
                        begin
                            latch_error(b64d_pkg::STATUS_OVERFLOW);
                        end
                        else
                        begin
                            add_item(held_sextets[11:4], 1'b1, b64d_pkg::STATUS_OK,
                                     16'd0, 1'b0);
                            bytes_out += 1;
                        end
                    end
                end
                add_item(8'd0, 1'b0, status, 16'(bytes_out), 1'b1);
                clear_text();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // check one result item against the oldest expectation
        function void check_result(b64d_pkg::result_t got);
            b64d_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t ns: unexpected result item, actual byte %0d is_data %0d",
                         $time, got.data_byte, got.is_data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("is_data", want.is_data, got.is_data);
            compare_field("decode_status", want.decode_status, got.decode_status);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // text_char[7:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;      // data_byte[7:0], decode_status[9:8], byte_count[25:10]
    logic        m_axis_tuser;      // is_data
    logic        m_axis_tlast;

    decoder_scoreboard sb;
    logic        long_hold_req;
    int unsigned chars_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;

    base64_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // monitors: predict on each accepted character, check each result item
    always @(posedge clk)
    begin
        b64d_pkg::result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_char(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data_byte = m_axis_tdata[7:0];
                got.is_data = m_axis_tuser;
                got.decode_status = m_axis_tdata[9:8];
                got.byte_count = m_axis_tdata[25:10];
                got.last_of_run = m_axis_tlast;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: stall patterns of its own, plus one long hold-off on request
    initial
    begin
        int unsigned pattern;
        int unsigned pattern_left;
        int unsigned tick;
        m_axis_tready = 1'b0;
        pattern = 0;
        pattern_left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (long_hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                m_axis_tready = 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = $urandom_range(0, 3);
                    pattern_left = $urandom_range(8, 64);
                end
                pattern_left--;
                case (pattern)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = $urandom_range(0, 1);
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ((tick % 5) != 0);
                endcase
            end
        end
    end

    // offer one character and wait for its handshake, in random bursts
    task automatic send_char(input logic [7:0] ch, input logic end_of_text);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = ch;
        s_axis_tlast = end_of_text;
        do
        begin
            @(posedge clk);
        end
        while (!(s_axis_tvalid && s_axis_tready));
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s, input logic end_of_text);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], end_of_text && (i == s.len() - 1));
        end
    endtask

    // sender goes quiet until every expected item has come
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // write max_output_bytes with the block idle
    task automatic write_limit(input logic [15:0] value);
        drain();
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = value;
        @(posedge clk);
        sb.set_limit(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] alphabet_char(int unsigned v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 62) ? "+" : "/";
    endfunction

    // one random text: mostly well formed, some broken, some noise
    task automatic send_random_text();
        logic [7:0]  text[$];
        int unsigned kind;
        int unsigned groups;
        int unsigned tail;
        int unsigned junk;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10)
                                                 : $urandom_range(0, 3);
            tail = $urandom_range(0, 3);
            for (int i = 0; i < groups * 4 + tail; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    text.push_back(8'h0A);
                end
                text.push_back(alphabet_char($urandom_range(0, 63)));
            end
            // padding, sometimes with stray characters after it
            if (tail >= 2 && $urandom_range(0, 1) == 1)
            begin
                repeat (4 - tail) text.push_back("=");
                if ($urandom_range(0, 3) == 0)
                begin
                    junk = $urandom_range(1, 3);
                    repeat (junk) text.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (text.size() == 0)
            begin
                text.push_back(($urandom_range(0, 1) == 1) ? 8'h0A : 8'h3D);
            end
            // broken text: one character replaced by any byte
            if (kind <= 2)
            begin
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic send_random(input int unsigned count);
        int unsigned start;
        start = chars_sent;
        while (chars_sent - start < count)
        begin
            send_random_text();
        end
    endtask

    // main sequence
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tlast = 1'b0;
        long_hold_req = 1'b0;
        chars_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed texts at the reset limit
        send_string("TWFu", 1'b1);
        send_string("AZa\nz09+/", 1'b1);
        // pad, then an invalid byte that must be ignored
        send_string("QQ=", 1'b0);
        send_char(8'hFF, 1'b1);
        // three-sextet tail
        send_string("QUI", 1'b1);
        // high byte error, carriage return dropped, no tail bytes
        send_char(8'h80, 1'b0);
        send_char(8'h0D, 1'b0);
        send_string("QQ", 1'b1);
        // single leftover sextet is discarded
        send_string("Q", 1'b1);
        send_char(8'h20, 1'b1);
        send_char(8'h00, 1'b1);

        // receiver holds off while characters keep coming
        long_hold_req = 1'b1;
        send_random(110);

        write_limit(16'd0);
        send_random(50);

        write_limit(16'hFFFF);
        send_random(50);
        drain();
        send_random(60);

        write_limit(16'($urandom_range(1, 12)));
        send_random(80);

        write_limit(16'($urandom_range(3, 20)));
        send_random(80);

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_decode.sv
sv/b64d_queue.sv
sv/base64_stream_decoder.sv
sim/base64_stream_decoder_tb.sv
